FILE: rtl/fhm_pkg.sv
// Package of the FIFO handoff mutex: status codes and parameter defaults.
// Used by fifo_handoff_mutex_core and the testbench; it depends on nothing.
package fhm_pkg;

  localparam int unsigned MaxWaitersDefault = 16;
  localparam int unsigned IdBitsDefault     = 8;

  localparam int unsigned StatusBits = 3;
  localparam int unsigned IdPortBits = 8;

  typedef enum logic [StatusBits-1:0] {
    ST_OK         = 3'd0,
    ST_QUEUED     = 3'd1,
    ST_DEADLOCK   = 3'd2,
    ST_NOT_HOLDER = 3'd3,
    ST_FULL       = 3'd4
  } status_e;

endpackage

FILE: rtl/fifo_handoff_mutex_core.sv
// Top level of the FIFO handoff mutex: holder register, queue pointers and control.
// Depends on fhm_pkg and on fhm_ram, which stores the waiting requesters.
//
//  channel   ports                                    handshake
//  request   func_i, requester_id_i                   start high while busy low
//  result    status_o, handoff_valid_o, handoff_id_o, done_o high for one cycle
//            is_locked_o, holder_out_o, has_waiters_o,
//            is_free_o
//
// The edge that accepts a request also reads the queue head from the RAM; while busy
// is high, the state is updated, the queue tail is written and the result is
// registered, which is shown with done_o in the cycle after that. busy is high for
// one cycle, so a new request is taken only once busy is low again. Reset clears
// the holder and the queue pointers at once; no clearing pass is needed. The
// receiver cannot stall, so nothing waits on the output side.
module fifo_handoff_mutex_core #(
  parameter int unsigned MAX_WAITERS = fhm_pkg::MaxWaitersDefault,
  parameter int unsigned ID_BITS     = fhm_pkg::IdBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            func_i,
  input  logic [fhm_pkg::IdPortBits-1:0]  requester_id_i,
  output logic                            done_o,
  output logic [fhm_pkg::StatusBits-1:0]  status_o,
  output logic                            handoff_valid_o,
  output logic [fhm_pkg::IdPortBits-1:0]  handoff_id_o,
  output logic                            is_locked_o,
  output logic [fhm_pkg::IdPortBits-1:0]  holder_out_o,
  output logic                            has_waiters_o,
  output logic                            is_free_o
);

  localparam int unsigned PtrW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int unsigned CntW = $clog2(MAX_WAITERS + 1);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(MAX_WAITERS - 1);
  localparam logic [CntW-1:0] FullCount = CntW'(MAX_WAITERS);

  logic               busy_q;
  logic               op_q;
  logic [ID_BITS-1:0] id_q;
  logic               holder_valid_q, holder_valid_d;
  logic [ID_BITS-1:0] holder_id_q, holder_id_d;
  logic [PtrW-1:0]    head_q, head_d;
  logic [PtrW-1:0]    tail_q, tail_d;
  logic [CntW-1:0]    count_q, count_d;

  logic               accept;
  logic               ram_we;
  logic [ID_BITS-1:0] ram_rdata;

  fhm_pkg::status_e   status_d;
  logic               hv_d;
  logic [ID_BITS-1:0] hid_d;

  logic                            done_q;
  logic [fhm_pkg::StatusBits-1:0]  status_q;
  logic                            hv_q;
  logic [fhm_pkg::IdPortBits-1:0]  hid_q;
  logic                            locked_q;
  logic [fhm_pkg::IdPortBits-1:0]  holder_out_q;
  logic                            waiters_q;
  logic                            free_q;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  fhm_ram #(
    .Width (ID_BITS),
    .Depth (MAX_WAITERS)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (id_q),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    holder_valid_d = holder_valid_q;
    holder_id_d    = holder_id_q;
    head_d         = head_q;
    tail_d         = tail_q;
    count_d        = count_q;
    status_d       = fhm_pkg::ST_OK;
    hv_d           = 1'b0;
    hid_d          = '0;
    ram_we         = 1'b0;
    if (!op_q) begin
      priority if (!holder_valid_q) begin
        holder_valid_d = 1'b1;
        holder_id_d    = id_q;
      end else if (holder_id_q == id_q) begin
        status_d = fhm_pkg::ST_DEADLOCK;
      end else if (count_q == FullCount) begin
        status_d = fhm_pkg::ST_FULL;
      end else begin
        ram_we   = busy_q;
        tail_d   = (tail_q == LastSlot) ? '0 : tail_q + 1'b1;
        count_d  = count_q + 1'b1;
        status_d = fhm_pkg::ST_QUEUED;
      end
    end else begin
      priority if (!holder_valid_q || holder_id_q != id_q) begin
        status_d = fhm_pkg::ST_NOT_HOLDER;
      end else if (count_q != '0) begin
        hv_d        = 1'b1;
        hid_d       = ram_rdata;
        holder_id_d = ram_rdata;
        head_d      = (head_q == LastSlot) ? '0 : head_q + 1'b1;
        count_d     = count_q - 1'b1;
      end else begin
        holder_valid_d = 1'b0;
        holder_id_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q         <= 1'b0;
      done_q         <= 1'b0;
      holder_valid_q <= 1'b0;
      holder_id_q    <= '0;
      head_q         <= '0;
      tail_q         <= '0;
      count_q        <= '0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) begin
        holder_valid_q <= holder_valid_d;
        holder_id_q    <= holder_id_d;
        head_q         <= head_d;
        tail_q         <= tail_d;
        count_q        <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= func_i;
      id_q <= ID_BITS'(requester_id_i);
    end
    if (busy_q) begin
      status_q     <= status_d;
      hv_q         <= hv_d;
      hid_q        <= fhm_pkg::IdPortBits'(hid_d);
      locked_q     <= holder_valid_d;
      holder_out_q <= holder_valid_d ? fhm_pkg::IdPortBits'(holder_id_d) : '0;
      waiters_q    <= (count_d != '0);
      free_q       <= !holder_valid_d && (count_d == '0);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign handoff_valid_o = hv_q;
  assign handoff_id_o    = hid_q;
  assign is_locked_o     = locked_q;
  assign holder_out_o    = holder_out_q;
  assign has_waiters_o   = waiters_q;
  assign is_free_o       = free_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && !done_q)
    else $error("Accepted request did not enter the busy cycle.");

  a_done_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> done_q && !busy_q)
    else $error("Result strobe did not follow the busy cycle.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("Wait queue count exceeds its depth.");

  a_waiters_need_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) |-> holder_valid_q)
    else $error("Requesters wait while the mutex has no holder.");

  a_handoff_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && hv_q) |-> (status_q == fhm_pkg::ST_OK) && locked_q)
    else $error("Handoff reported without a granted unlock.");

endmodule

FILE: rtl/fhm_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Holds the wait queue of the mutex core; it uses no package items.
module fhm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: verif/fhm_tb_pkg.sv
// Shared testbench types for the FIFO handoff mutex: request operations and result words.
// Depends on fhm_pkg for the status codes.
package fhm_tb_pkg;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } mutex_op_e;

  typedef struct packed {
    fhm_pkg::status_e status;
    logic             handoff_valid;
    logic [7:0]       handoff_id;
    logic             is_locked;
    logic [7:0]       holder;
    logic             has_waiters;
    logic             is_free;
  } mutex_result_t;

endpackage

FILE: verif/fhm_checker.sv
// Checker for the FIFO handoff mutex: tracks holder and wait queue, predicts every result
// word and compares it field by field. Depends on fhm_pkg and fhm_tb_pkg.
module fhm_checker #(
  parameter int unsigned MAX_WAITERS = fhm_pkg::MaxWaitersDefault,
  parameter int unsigned ID_BITS     = fhm_pkg::IdBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic       func_i,
  input  logic [7:0] requester_id_i,
  input  logic       done_i,
  input  logic [2:0] status_i,
  input  logic       handoff_valid_i,
  input  logic [7:0] handoff_id_i,
  input  logic       is_locked_i,
  input  logic [7:0] holder_out_i,
  input  logic       has_waiters_i,
  input  logic       is_free_i,
  output int         errors_o,
  output int         pending_o,
  output int         handoffs_o,
  output int         full_o
);

  localparam logic [7:0] IdMask = 8'((1 << ID_BITS) - 1);

  logic                      owned;
  logic [7:0]                owner;
  logic [7:0]                waiters [MAX_WAITERS];
  int unsigned               head;
  int unsigned               tail;
  int unsigned               count;
  fhm_tb_pkg::mutex_result_t expected_q [$];
  fhm_tb_pkg::mutex_result_t want;

  function automatic int unsigned next_slot(input int unsigned p);
    return (p + 1 >= MAX_WAITERS) ? 0 : p + 1;
  endfunction

  function automatic fhm_tb_pkg::mutex_result_t apply_request(
    input fhm_tb_pkg::mutex_op_e op,
    input logic [7:0]            raw
  );
    fhm_tb_pkg::mutex_result_t r;
    logic [7:0]                who;
    r = '0;
    who = raw & IdMask;
    r.status = fhm_pkg::ST_OK;
    if (op == fhm_tb_pkg::OP_LOCK) begin
      if (!owned) begin
        owned = 1'b1;
        owner = who;
      end else if (owner == who) begin
        r.status = fhm_pkg::ST_DEADLOCK;
      end else if (count >= MAX_WAITERS) begin
        r.status = fhm_pkg::ST_FULL;
      end else begin
        waiters[tail] = who;
        tail = next_slot(tail);
        count++;
        r.status = fhm_pkg::ST_QUEUED;
      end
    end else begin
      if (!owned || owner != who) begin
        r.status = fhm_pkg::ST_NOT_HOLDER;
      end else if (count > 0) begin
        r.handoff_valid = 1'b1;
        r.handoff_id = waiters[head];
        head = next_slot(head);
        count--;
        owner = r.handoff_id;
      end else begin
        owned = 1'b0;
        owner = '0;
      end
    end
    r.is_locked = owned;
    r.holder = owned ? owner : '0;
    r.has_waiters = (count > 0);
    r.is_free = !owned && count == 0;
    return r;
  endfunction

  task automatic check_field(input string name, input int exp_val, input int got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owned = 1'b0;
      owner = '0;
      head = 0;
      tail = 0;
      count = 0;
      expected_q.delete();
      errors_o = 0;
      pending_o = 0;
      handoffs_o = 0;
      full_o = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("Result word arrived with no request outstanding.");
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", want.status, status_i);
          check_field("handoff_valid", want.handoff_valid, handoff_valid_i);
          check_field("handoff_id", want.handoff_id, handoff_id_i);
          check_field("is_locked", want.is_locked, is_locked_i);
          check_field("holder_out", want.holder, holder_out_i);
          check_field("has_waiters", want.has_waiters, has_waiters_i);
          check_field("is_free", want.is_free, is_free_i);
          if (want.handoff_valid) handoffs_o++;
          if (want.status == fhm_pkg::ST_FULL) full_o++;
        end
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(apply_request(fhm_tb_pkg::mutex_op_e'(func_i), requester_id_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

FILE: verif/fifo_handoff_mutex_core_tb.sv
// Testbench top for the FIFO handoff mutex: clock, reset, request stimulus and verdict.
// Depends on fhm_pkg, fhm_tb_pkg, fhm_checker and the fifo_handoff_mutex_core RTL.
module fifo_handoff_mutex_core_tb;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       func_i = 1'b0;
  logic [7:0] requester_id_i = '0;
  logic       busy;
  logic       done_o;
  logic [2:0] status_o;
  logic       handoff_valid_o;
  logic [7:0] handoff_id_o;
  logic       is_locked_o;
  logic [7:0] holder_out_o;
  logic       has_waiters_o;
  logic       is_free_o;

  int         fail_count;
  int         pending;
  int         handoffs;
  int         full_refusals;
  int         words_sent = 0;
  int         words_back = 0;
  logic [7:0] last_holder = '0;
  logic [7:0] id_pool [8];

  fifo_handoff_mutex_core dut (.*);

  fhm_checker checker_i (
    .clk_i, .rst_ni,
    .start_i(start), .busy_i(busy), .func_i, .requester_id_i,
    .done_i(done_o), .status_i(status_o), .handoff_valid_i(handoff_valid_o),
    .handoff_id_i(handoff_id_o), .is_locked_i(is_locked_o), .holder_out_i(holder_out_o),
    .has_waiters_i(has_waiters_o), .is_free_i(is_free_o),
    .errors_o(fail_count), .pending_o(pending), .handoffs_o(handoffs),
    .full_o(full_refusals)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (done_o) begin
      words_back <= words_back + 1;
      last_holder <= holder_out_o;
    end
  end

  initial begin
    #3000000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_word(
    input fhm_tb_pkg::mutex_op_e op,
    input logic [7:0]            id,
    input int                    idle_pct
  );
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      func_i <= 1'($urandom);
      requester_id_i <= 8'($urandom);
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= op;
    requester_id_i <= id;
    do @(posedge clk_i); while (busy);
    words_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (words_back != words_sent);
  endtask

  task automatic random_phase(input int n, input int idle_pct);
    int                    lock_pct;
    fhm_tb_pkg::mutex_op_e op;
    logic [7:0]            id;
    lock_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) lock_pct = 25 * $urandom_range(3, 1);
      op = ($urandom_range(99) < lock_pct) ? fhm_tb_pkg::OP_LOCK : fhm_tb_pkg::OP_UNLOCK;
      if (op == fhm_tb_pkg::OP_UNLOCK) begin
        id = ($urandom_range(99) < 75) ? last_holder : id_pool[$urandom_range(7)];
      end else begin
        case ($urandom_range(9))
          0:       id = last_holder;
          1, 2, 3: id = 8'($urandom);
          default: id = id_pool[$urandom_range(7)];
        endcase
      end
      if ($urandom_range(99) < 3) id = 8'($urandom);
      send_word(op, id, idle_pct);
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    foreach (id_pool[k]) id_pool[k] = 8'($urandom);
    id_pool[0] = 8'h00;
    id_pool[1] = 8'hFF;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(fhm_tb_pkg::OP_UNLOCK, 8'h00, 0);
    send_word(fhm_tb_pkg::OP_LOCK, 8'h00, 0);
    send_word(fhm_tb_pkg::OP_LOCK, 8'h00, 0);
    send_word(fhm_tb_pkg::OP_UNLOCK, 8'hFF, 0);
    for (int i = 0; i < 16; i++) begin
      send_word(fhm_tb_pkg::OP_LOCK, (i == 0) ? 8'hFF : 8'(i * 17), 0);
    end
    send_word(fhm_tb_pkg::OP_LOCK, 8'h3C, 0);
    send_word(fhm_tb_pkg::OP_UNLOCK, 8'h00, 0);
    send_word(fhm_tb_pkg::OP_UNLOCK, 8'h00, 0);
    send_word(fhm_tb_pkg::OP_UNLOCK, 8'hFF, 0);
    drain();

    random_phase(600, 38);
    random_phase(600, 64);
    random_phase(550, 0);

    repeat (8) @(posedge clk_i);
    $display("Covered %0d requests with %0d ownership handoffs and %0d queue-full refusals.",
             words_sent, handoffs, full_refusals);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
